// File: design/ils_pkg.sv
// Package for the indexed list store: operation, status and state codes,
// and the control bundle that the top level broadcasts to the cell row.
// Depends on nothing.
package ils_pkg;

    // Index width that covers every position up to the largest capacity (64).
    localparam int IDX_W = 7;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_POP    = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_DUMP   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SH_HOLD   = 2'd0,
        SH_INSERT = 2'd1,
        SH_REMOVE = 2'd2,
        SH_ROTATE = 2'd3
    } t_shift;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } t_state;

    typedef struct packed {
        t_shift           shift;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] last;
    } t_cell_ctl;

endpackage

// File: design/ils_if.sv
// Valid/ready channel interfaces for the indexed list store.
// Command items flow in on ils_in_if, result items flow out on ils_out_if.
// Depends on nothing.
interface ils_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [5:0]         position;
    logic signed [15:0] real_part;
    logic signed [15:0] imag_part;

    modport source (output valid, operation, position, real_part, imag_part, input ready);
    modport sink   (input valid, operation, position, real_part, imag_part, output ready);
endinterface

interface ils_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [5:0]         list_size;
    logic signed [15:0] elem_real;
    logic signed [15:0] elem_imag;
    logic               elem_valid;
    logic               last;

    modport source (output valid, status, list_size, elem_real, elem_imag, elem_valid, last,
                    input ready);
    modport sink   (input valid, status, list_size, elem_real, elem_imag, elem_valid, last,
                    output ready);
endinterface

// File: design/indexed_list_store.sv
// Top level of the indexed list store: control, size counter, output register
// and a row of CAPACITY ils_cell instances.
// Depends on ils_pkg, ils_in_if, ils_out_if and ils_cell.
//
//  Port      Direction  Item contents
//  i_in      in         operation, position, real_part, imag_part
//  o_out     out        status, list_size, elem_real, elem_imag, elem_valid, last
//
// Every operation other than dump is decided and applied in the cycle its item
// is accepted; the whole cell row shifts in that same cycle, so one such item
// can be taken every cycle while the output register drains.
// A dump of a non-empty list first enters the dump state and then streams
// one element per dump step: the row rotates by one element at each step and the
// head cell is copied to the output register, so after count steps the row is
// back in its original order. No new item is taken during a dump.
// Reset (i_rst_n low, synchronous) empties the list and the output register;
// cell contents are not cleared, since only the first count cells are read.
// A stalled output holds its item and stalls the dump or the next command.
module indexed_list_store #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ils_in_if.sink       i_in,
    ils_out_if.source    o_out
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = ils_pkg::IDX_W;
    localparam int EW = 2 * DATA_WIDTH;

    // Control state.
    ils_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;

    // Output register. The element parts are held at the 16-bit port width.
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_status, n_status;
    logic [5:0]       r_size, n_size;
    logic [31:0]      r_elem, n_elem;
    logic             r_elem_valid, n_elem_valid;
    logic             r_last, n_last;

    ils_pkg::t_cell_ctl w_ctl;
    logic [EW-1:0]    w_cell [CAPACITY];
    logic [EW-1:0]    w_new;

    logic             w_out_free;
    logic             w_accept;
    logic             w_dump_step;
    logic             w_dump_last;
    logic [IW-1:0]    w_count_x;
    logic [IW-1:0]    w_pos_x;
    logic [IW-1:0]    w_idx_x;
    logic signed [DATA_WIDTH-1:0] w_new_re;
    logic signed [DATA_WIDTH-1:0] w_new_im;
    logic signed [DATA_WIDTH-1:0] w_head_re;
    logic signed [DATA_WIDTH-1:0] w_head_im;

    assign w_out_free  = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == ils_pkg::S_IDLE) && w_out_free;
    assign w_accept    = i_in.valid && i_in.ready;

    assign w_count_x   = IW'(r_count);
    assign w_pos_x     = IW'(i_in.position);
    assign w_idx_x     = IW'(r_idx);

    // A dump step moves the head cell to the output register.
    assign w_dump_step = (r_state == ils_pkg::S_DUMP) && w_out_free;
    assign w_dump_last = (w_idx_x == w_count_x - IW'(1));

    // Parts are kept at DATA_WIDTH bits, sign-extended back to 16 on the way out.
    assign w_new_re  = DATA_WIDTH'(i_in.real_part);
    assign w_new_im  = DATA_WIDTH'(i_in.imag_part);
    assign w_new     = {w_new_im, w_new_re};
    assign w_head_re = w_cell[0][DATA_WIDTH-1:0];
    assign w_head_im = w_cell[0][EW-1:DATA_WIDTH];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_status     = r_status;
        n_size       = r_size;
        n_elem       = r_elem;
        n_elem_valid = r_elem_valid;
        n_last       = r_last;
        w_ctl.shift  = ils_pkg::SH_HOLD;
        w_ctl.pos    = w_pos_x;
        w_ctl.last   = w_count_x - IW'(1);

        if (w_accept) begin
            // Default answer for a one-result operation; the size is fixed below.
            n_status     = ils_pkg::ST_OK;
            n_elem       = '0;
            n_elem_valid = 1'b0;
            n_last       = 1'b1;
            n_out_valid  = 1'b1;
            case (ils_pkg::t_op'(i_in.operation))
                ils_pkg::OP_APPEND, ils_pkg::OP_INSERT: begin
                    if (ils_pkg::t_op'(i_in.operation) == ils_pkg::OP_APPEND) begin
                        w_ctl.pos = w_count_x;
                    end
                    // The index check comes before the full check.
                    if (w_ctl.pos > w_count_x) begin
                        n_status = ils_pkg::ST_BAD_INDEX;
                    end else if (w_count_x >= IW'(CAPACITY)) begin
                        n_status = ils_pkg::ST_FULL;
                    end else begin
                        w_ctl.shift = ils_pkg::SH_INSERT;
                        n_count     = r_count + CW'(1);
                    end
                end
                ils_pkg::OP_REMOVE: begin
                    if (w_pos_x >= w_count_x) begin
                        n_status = ils_pkg::ST_BAD_INDEX;
                    end else begin
                        w_ctl.shift = ils_pkg::SH_REMOVE;
                        n_count     = r_count - CW'(1);
                    end
                end
                ils_pkg::OP_POP: begin
                    if (r_count == '0) begin
                        n_status = ils_pkg::ST_EMPTY;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
                ils_pkg::OP_CLEAR: begin
                    n_count = '0;
                end
                ils_pkg::OP_DUMP: begin
                    // An empty list answers with one invalid element; otherwise
                    // the elements stream out of the dump state.
                    if (r_count != '0) begin
                        n_out_valid = r_out_valid && !o_out.ready;
                        n_state     = ils_pkg::S_DUMP;
                        n_idx       = '0;
                    end
                end
                default: begin
                    // Unused codes are swallowed without a result.
                    n_out_valid = r_out_valid && !o_out.ready;
                end
            endcase
            n_size = 6'(n_count);
        end else if (w_dump_step) begin
            w_ctl.shift  = ils_pkg::SH_ROTATE;
            n_out_valid  = 1'b1;
            n_status     = ils_pkg::ST_OK;
            n_size       = 6'(r_count);
            n_elem       = {16'(w_head_im), 16'(w_head_re)};
            n_elem_valid = 1'b1;
            n_last       = w_dump_last;
            n_idx        = r_idx + CW'(1);
            if (w_dump_last) begin
                n_state = ils_pkg::S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ils_pkg::S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_size       <= n_size;
        r_elem       <= n_elem;
        r_elem_valid <= n_elem_valid;
        r_last       <= n_last;
    end

    // The cell row: each cell sees both neighbors, the new element and the head.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [EW-1:0] w_left;
        logic [EW-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_cell[g];
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign w_right = w_cell[g];
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end

        ils_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_new   (w_new),
            .i_left  (w_left),
            .i_right (w_right),
            .i_wrap  (w_cell[0]),
            .o_data  (w_cell[g])
        );
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_status;
    assign o_out.list_size  = r_size;
    assign o_out.elem_real  = r_elem[15:0];
    assign o_out.elem_imag  = r_elem[31:16];
    assign o_out.elem_valid = r_elem_valid;
    assign o_out.last       = r_last;

    // The size never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        IW'(r_count) <= IW'(CAPACITY))
        else $error("list size above capacity");

    // The dump walk stays inside the list.
    a_dump_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ils_pkg::S_DUMP) |-> (r_idx < r_count))
        else $error("dump index beyond list size");

    // No command is taken while a dump is streaming.
    a_no_accept_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ils_pkg::S_DUMP) |-> !i_in.ready)
        else $error("input ready during dump");

    // The final dump step returns to idle with a closing item.
    a_dump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dump_step && w_dump_last) |=> (r_state == ils_pkg::S_IDLE) && r_last && r_out_valid)
        else $error("dump did not close properly");

    // The size does not change during a dump.
    a_dump_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ils_pkg::S_DUMP) |=> $stable(r_count))
        else $error("size changed during dump");

endmodule

// File: design/ils_cell.sv
// One storage cell of the list row: holds one complex element.
// Uses ils_pkg for the shift control bundle.
// Depends on ils_pkg.
module ils_cell #(
    parameter int DATA_WIDTH = 16,
    parameter int INDEX      = 0
) (
    input  logic                      i_clk,
    input  ils_pkg::t_cell_ctl        i_ctl,
    input  logic [2*DATA_WIDTH-1:0]   i_new,
    input  logic [2*DATA_WIDTH-1:0]   i_left,
    input  logic [2*DATA_WIDTH-1:0]   i_right,
    input  logic [2*DATA_WIDTH-1:0]   i_wrap,
    output logic [2*DATA_WIDTH-1:0]   o_data
);

    localparam logic [ils_pkg::IDX_W-1:0] MY_IDX = ils_pkg::IDX_W'(INDEX);

    logic [2*DATA_WIDTH-1:0] r_data;
    logic [2*DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.shift)
            ils_pkg::SH_INSERT: begin
                if (MY_IDX > i_ctl.pos) begin
                    n_data = i_left;
                end else if (MY_IDX == i_ctl.pos) begin
                    n_data = i_new;
                end
            end
            ils_pkg::SH_REMOVE: begin
                if (MY_IDX >= i_ctl.pos) begin
                    n_data = i_right;
                end
            end
            ils_pkg::SH_ROTATE: begin
                // The head leaves at the front and comes back in at the tail.
                if (MY_IDX < i_ctl.last) begin
                    n_data = i_right;
                end else if (MY_IDX == i_ctl.last) begin
                    n_data = i_wrap;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
